// ===== hdl/pbc_pkg.sv =====
package pbc_pkg;

  localparam int NUM_PARTITIONS = 16;
  localparam int RAW_PARTITION  = 2;
  localparam int IDX_W          = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam bit RAW_VALID      = RAW_PARTITION < NUM_PARTITIONS;

  localparam int PART_W      = 4;
  localparam int BLK_W       = 31;
  localparam int BC_W        = 31;
  localparam int WORD_W      = 32;
  localparam int BPS_W       = 7;
  localparam int SPC_W       = 24;
  localparam int CYL_W       = 32;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int BLOCK_SHIFT = 9;
  localparam int BLOCK_MASK  = (1 << BLOCK_SHIFT) - 1;

  // partition end in blocks, then absolute/label block with one carry bit
  localparam int END_W = WORD_W + BPS_W;
  localparam int ABS_W = END_W + 1;
  // rounded-up block count of one request
  localparam int SZ_W  = BC_W + 1 - BLOCK_SHIFT;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_CHECK = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_END      = 3'd1,
    ST_PAST     = 3'd2,
    ST_LABEL    = 3'd3,
    ST_LOADED   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPS        = 2'd0,
    REG_LABEL_BASE = 2'd1,
    REG_SPC        = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              cmd;
    logic [PART_W-1:0] partition;
    logic [BLK_W-1:0]  block_number;
    logic [BC_W-1:0]   byte_count;
    logic              is_read;
    logic              allow_label_write;
    logic [WORD_W-1:0] entry_size;
    logic [WORD_W-1:0] entry_offset;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BC_W-1:0]     new_byte_count;
    logic [BC_W-1:0]     residual;
    logic [CYL_W-1:0]    cylinder;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    value;
  } cfg_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] offset;
  } entry_t;

endpackage

// ===== hdl/pbc_if.sv =====
interface pbc_in_if;
  logic               valid;
  logic               ready;
  pbc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pbc_out_if;
  logic               valid;
  logic               ready;
  pbc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pbc_cfg_if;
  logic               valid;
  logic               ready;
  pbc_pkg::cfg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/partition_bounds_check_unit.sv =====
// Partition bounds checker.
// in_i carries load beats (cmd 0: write partition size/offset into the
// table) and check beats (cmd 1: test a transfer against that table).
// out_o returns exactly one result beat for every input beat, in order.
// cfg_i writes blocks_per_sector, label_base and sectors_per_cylinder;
// it is always ready and is meant to be written while the unit is idle.
// Sequence: a load goes straight to the done state. A check runs three
// multiply steps on one shared 32x7 multiplier and a bounds step; end of
// partition and past end then return, label protected after one more
// label step. An accepted check runs the 40-step restoring divider for
// the cylinder and then returns.
// Throughput: one item at a time; in_i is ready again the cycle after
// the result is moved into the output register.
// Reset clears the table (all entries read as zero) and sets the
// registers to blocks_per_sector 1, label_base 0, sectors_per_cylinder 1.
// When out_o stalls, the result waits in the output register; one more
// item may be accepted and finished behind it before in_i stalls.
module partition_bounds_check_unit (
  input logic        clk_i,
  input logic        rst_ni,
  pbc_cfg_if.sink    cfg_i,
  pbc_in_if.sink     in_i,
  pbc_out_if.source  out_o
);

  localparam int WordW  = pbc_pkg::WORD_W;
  localparam int EndW   = pbc_pkg::END_W;
  localparam int AbsW   = pbc_pkg::ABS_W;
  localparam int SzW    = pbc_pkg::SZ_W;
  localparam int BcW    = pbc_pkg::BC_W;
  localparam int Shift  = pbc_pkg::BLOCK_SHIFT;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MEND  = 8'b00000010,
    S_MLBL  = 8'b00000100,
    S_MABS  = 8'b00001000,
    S_BOUND = 8'b00010000,
    S_LABEL = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_e;

  state_e                         state_q, state_d;
  pbc_pkg::in_item_t              item_q;
  logic [WordW-1:0]               psize_q, poff_q, raw_q;
  logic [EndW-1:0]                end_q;
  logic [AbsW-1:0]                label_q, abs_q;
  logic [SzW-1:0]                 sz_q;
  pbc_pkg::out_item_t             res_q, out_q;
  logic                           out_valid_q;
  logic [pbc_pkg::BPS_W-1:0]      bps_q;
  logic [WordW-1:0]               label_base_q;
  logic [pbc_pkg::SPC_W-1:0]      spc_q;

  logic                           in_fire, cfg_fire, out_free;
  pbc_pkg::entry_t                wr_entry, rd_entry;
  logic [WordW-1:0]               raw_offset;
  logic [WordW-1:0]               mul_a;
  logic [EndW-1:0]                prod;
  logic [BcW:0]                   rnd;
  logic [SzW-1:0]                 sz0, trunc_sz;
  logic [EndW-1:0]                blk_ext, reach, trunc_full;
  logic                           over, early;
  logic [AbsW:0]                  abs_end;
  logic                           prot;
  logic                           div_start, div_done;
  logic [pbc_pkg::CYL_W-1:0]      quotient;

  assign in_fire   = in_i.valid && in_i.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready  = state_q == S_IDLE;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q        <= pbc_pkg::BPS_W'(1);
      label_base_q <= '0;
      spc_q        <= pbc_pkg::SPC_W'(1);
    end else if (cfg_fire) begin
      unique case (cfg_i.data.index)
        pbc_pkg::REG_BPS:        bps_q        <= cfg_i.data.value[pbc_pkg::BPS_W-1:0];
        pbc_pkg::REG_LABEL_BASE: label_base_q <= cfg_i.data.value;
        pbc_pkg::REG_SPC:        spc_q        <= cfg_i.data.value[pbc_pkg::SPC_W-1:0];
        default: ;
      endcase
    end
  end

  assign wr_entry.size   = in_i.data.entry_size;
  assign wr_entry.offset = in_i.data.entry_offset;

  pbc_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (in_fire && (in_i.data.cmd == pbc_pkg::CMD_LOAD)),
    .part_i       (in_i.data.partition),
    .wr_entry_i   (wr_entry),
    .rd_entry_o   (rd_entry),
    .raw_offset_o (raw_offset)
  );

  // shared sector-to-block multiplier
  always_comb begin
    unique case (state_q)
      S_MEND:  mul_a = psize_q;
      S_MLBL:  mul_a = raw_q;
      default: mul_a = poff_q;
    endcase
  end

  assign prod = EndW'(mul_a) * EndW'(bps_q);

  // bounds test
  assign rnd        = (BcW + 1)'(item_q.byte_count) + (BcW + 1)'(pbc_pkg::BLOCK_MASK);
  assign sz0        = SzW'(rnd >> Shift);
  assign blk_ext    = EndW'(item_q.block_number);
  assign reach      = blk_ext + EndW'(sz0);
  assign over       = reach > end_q;
  assign early      = over && (blk_ext >= end_q);
  assign trunc_full = end_q - blk_ext;
  assign trunc_sz   = trunc_full[SzW-1:0];

  // label overlap test
  assign abs_end = (AbsW + 1)'(abs_q) + (AbsW + 1)'(sz_q);
  assign prot    = (abs_q <= label_q) && (abs_end > (AbsW + 1)'(label_q)) &&
                   !item_q.is_read && !item_q.allow_label_write;

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.data.cmd == pbc_pkg::CMD_LOAD) ? S_DONE : S_MEND;
        end
      end
      S_MEND:  state_d = S_MLBL;
      S_MLBL:  state_d = S_MABS;
      S_MABS:  state_d = S_BOUND;
      S_BOUND: state_d = early ? S_DONE : S_LABEL;
      S_LABEL: begin
        if (prot) begin
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_q                <= in_i.data;
          psize_q               <= rd_entry.size;
          poff_q                <= rd_entry.offset;
          raw_q                 <= raw_offset;
          res_q.status          <= pbc_pkg::ST_LOADED;
          res_q.new_byte_count  <= '0;
          res_q.residual        <= '0;
          res_q.cylinder        <= '0;
        end
      end
      S_MEND: end_q   <= prod;
      S_MLBL: label_q <= AbsW'(prod) + AbsW'(label_base_q);
      S_MABS: abs_q   <= AbsW'(prod) + AbsW'(item_q.block_number);
      S_BOUND: begin
        res_q.cylinder <= '0;
        priority if (over && (blk_ext == end_q)) begin
          res_q.status         <= pbc_pkg::ST_END;
          res_q.new_byte_count <= item_q.byte_count;
          res_q.residual       <= item_q.byte_count;
          sz_q                 <= sz0;
        end else if (early) begin
          res_q.status         <= pbc_pkg::ST_PAST;
          res_q.new_byte_count <= item_q.byte_count;
          res_q.residual       <= '0;
          sz_q                 <= sz0;
        end else if (over) begin
          // clip to the partition end
          res_q.new_byte_count <= BcW'(trunc_sz) << Shift;
          res_q.residual       <= '0;
          sz_q                 <= trunc_sz;
        end else begin
          res_q.new_byte_count <= item_q.byte_count;
          res_q.residual       <= '0;
          sz_q                 <= sz0;
        end
      end
      S_LABEL: begin
        if (prot) begin
          res_q.status <= pbc_pkg::ST_LABEL;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_q.status   <= pbc_pkg::ST_ACCEPTED;
          res_q.cylinder <= quotient;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  pbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (abs_q),
    .divisor_i  (spc_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != S_IDLE)
    else $error("accepted beat did not start work");

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> ($past(state_q == S_LABEL) || $past(state_q == S_DIV)))
    else $error("divider state entered out of sequence");

  a_residual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != pbc_pkg::ST_END) |-> out_q.residual == '0)
    else $error("nonzero residual outside end of partition");

  a_cylinder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != pbc_pkg::ST_ACCEPTED) |-> out_q.cylinder == '0)
    else $error("cylinder set on a refused or load result");

endmodule

// ===== hdl/pbc_table.sv =====
module pbc_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [pbc_pkg::PART_W-1:0]  part_i,
  input  pbc_pkg::entry_t             wr_entry_i,
  output pbc_pkg::entry_t             rd_entry_o,
  output logic [pbc_pkg::WORD_W-1:0]  raw_offset_o
);

  localparam int IdxW = pbc_pkg::IDX_W;
  localparam logic [IdxW-1:0] RawIdx = IdxW'(pbc_pkg::RAW_PARTITION);

  logic [pbc_pkg::NUM_PARTITIONS-1:0] valid_q;
  pbc_pkg::entry_t                    entry_q [pbc_pkg::NUM_PARTITIONS];
  logic                               in_range;
  logic [IdxW-1:0]                    idx;

  assign in_range = int'(part_i) < pbc_pkg::NUM_PARTITIONS;
  assign idx      = IdxW'(part_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i && in_range) begin
      valid_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      entry_q[idx] <= wr_entry_i;
    end
  end

  // entries never loaded read as zero
  assign rd_entry_o   = (in_range && valid_q[idx]) ? entry_q[idx] : '0;
  assign raw_offset_o = (pbc_pkg::RAW_VALID && valid_q[RawIdx]) ? entry_q[RawIdx].offset : '0;

endmodule

// ===== hdl/pbc_div.sv =====
module pbc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pbc_pkg::ABS_W-1:0]  dividend_i,
  input  logic [pbc_pkg::SPC_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [pbc_pkg::CYL_W-1:0]  quotient_o
);

  localparam int DvdW  = pbc_pkg::ABS_W;
  localparam int DsrW  = pbc_pkg::SPC_W;
  localparam int StepW = $clog2(DvdW);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [DsrW-1:0]  rem_q;
  logic [DsrW-1:0]  dsr_q;
  // dividend bits shift out the top while quotient bits enter the bottom
  logic [DvdW-1:0]  qd_q;
  logic [DsrW:0]    trial;
  logic [DsrW:0]    diff;
  logic             ge;

  assign trial = {rem_q, qd_q[DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(DvdW - 1);
    end else begin
      done_q <= busy_q && (step_q == '0);
      if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      qd_q  <= dividend_i;
    end else if (busy_q) begin
      // zero divisor keeps every trial, giving an all-ones quotient
      rem_q <= ge ? diff[DsrW-1:0] : trial[DsrW-1:0];
      qd_q  <= {qd_q[DvdW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = qd_q[pbc_pkg::CYL_W-1:0];

endmodule
